// ===== hdl/shtp_pkg.sv =====
// Package for the sensor-hub transport report parser: ids, kinds, sizes and the result beat.
`timescale 1ns / 1ps

package shtp_pkg;

  // Record ids
  localparam logic [7:0] ID_ACCEL     = 8'h01;
  localparam logic [7:0] ID_GYRO      = 8'h02;
  localparam logic [7:0] ID_MAG       = 8'h03;
  localparam logic [7:0] ID_LINEAR    = 8'h04;
  localparam logic [7:0] ID_ROTATION  = 8'h05;
  localparam logic [7:0] ID_GRAVITY   = 8'h06;
  localparam logic [7:0] ID_GAME_ROT  = 8'h08;
  localparam logic [7:0] ID_GEO_ROT   = 8'h09;
  localparam logic [7:0] ID_REBASE    = 8'hFA;
  localparam logic [7:0] ID_BASE_TS   = 8'hFB;

  // Sensor kinds on the result
  localparam logic [2:0] KIND_ACCEL    = 3'd0;
  localparam logic [2:0] KIND_GYRO     = 3'd1;
  localparam logic [2:0] KIND_MAG      = 3'd2;
  localparam logic [2:0] KIND_LINEAR   = 3'd3;
  localparam logic [2:0] KIND_GRAVITY  = 3'd4;
  localparam logic [2:0] KIND_ROTATION = 3'd5;
  localparam logic [2:0] KIND_GAME_ROT = 3'd6;
  localparam logic [2:0] KIND_GEO_ROT  = 3'd7;

  // Configuration register indexes
  localparam logic CFG_IDX_INPUT_CH = 1'b0;
  localparam logic CFG_IDX_WAKE_CH  = 1'b1;

  // Frame layout
  localparam int unsigned HDR_CHANNEL_POS = 2;
  localparam int unsigned FIRST_REC_POS   = 4;
  localparam int unsigned PAYLOAD_FIRST   = 4;
  localparam int unsigned PAYLOAD_END     = 12;
  localparam logic [2:0]  TS_SKIP_BYTES   = 3'd4;

  typedef struct packed {
    logic               report_valid;
    logic [2:0]         sensor_kind;
    logic signed [15:0] value_x;
    logic signed [15:0] value_y;
    logic signed [15:0] value_z;
    logic signed [15:0] value_w;
    logic               frame_done;
    logic               frame_updated;
  } shtp_result_t;

  // Record length in bytes including the id; zero for an unknown id and for the base timestamp.
  function automatic logic [3:0] rec_size(input logic [7:0] id);
    case (id)
      ID_REBASE:                                               rec_size = 4'd5;
      ID_ACCEL, ID_GYRO, ID_MAG, ID_LINEAR, ID_GRAVITY:        rec_size = 4'd10;
      ID_GAME_ROT:                                             rec_size = 4'd12;
      ID_ROTATION, ID_GEO_ROT:                                 rec_size = 4'd14;
      default:                                                 rec_size = 4'd0;
    endcase
  endfunction

  function automatic logic [2:0] kind_of(input logic [7:0] id);
    case (id)
      ID_ACCEL:    kind_of = KIND_ACCEL;
      ID_GYRO:     kind_of = KIND_GYRO;
      ID_MAG:      kind_of = KIND_MAG;
      ID_LINEAR:   kind_of = KIND_LINEAR;
      ID_GRAVITY:  kind_of = KIND_GRAVITY;
      ID_ROTATION: kind_of = KIND_ROTATION;
      ID_GAME_ROT: kind_of = KIND_GAME_ROT;
      default:     kind_of = KIND_GEO_ROT;
    endcase
  endfunction

endpackage

// ===== hdl/shtp_sensor_report_parser.sv =====
// Sensor-hub transport frame parser: one byte a beat in, decoded sensor reports out.
// Result beats go to the output register, or to the skid register while it is held.
// One byte per cycle unless in_stall; the byte-state update is one combinational pass.
// An output register plus one skid register part the two sides; in_stall rises only
// while the skid register holds a beat.
// Reset (rst_n low, synchronous) clears frame state and both output valid flags and sets
// the channel registers to input 3, wake 4; the payload bytes are not reset.
`timescale 1ns / 1ps

module shtp_sensor_report_parser
  import shtp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_wdata,
  // byte input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_report_valid,
  output logic [2:0]         out_sensor_kind,
  output logic signed [15:0] out_value_x,
  output logic signed [15:0] out_value_y,
  output logic signed [15:0] out_value_z,
  output logic signed [15:0] out_value_w,
  output logic               out_frame_done,
  output logic               out_frame_updated
);

  // Position saturates at MAX_FRAME_BYTES, so it must hold that value.
  localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);

  // Channel registers
  logic [3:0] in_ch_r, wake_ch_r;

  // Frame state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             acc_r, acc_nxt;       // channel matched
  logic             stop_r, stop_nxt;     // unknown id seen
  logic [7:0]       id_r, id_nxt;         // id of record in progress
  logic [3:0]       left_r, left_nxt;     // record bytes still to come
  logic [2:0]       skip_r, skip_nxt;     // timestamp bytes still to skip
  logic             seen_r, seen_nxt;     // a report decoded this frame
  logic [7:0]       pay_r [8];            // record bytes 4..11
  logic [7:0]       pay_nxt [8];

  // Output side: main register and skid register
  shtp_result_t res;
  logic         emit;
  shtp_result_t out_d_r, skid_d_r;
  logic         out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;

  logic       in_fire, out_take;
  logic [3:0] off, sz;
  logic [2:0] wr_idx;

  assign in_stall = skid_v_r;
  assign in_fire  = in_valid && !skid_v_r;
  assign out_take = out_v_r && !out_stall;

  // ---------------------------------------------------------------------------
  // Per-byte parse. Payload writes are bypassed into the result so a report that
  // completes on a stored byte sees that byte.
  // ---------------------------------------------------------------------------
  always_comb begin
    pos_nxt  = pos_r;
    acc_nxt  = acc_r;
    stop_nxt = stop_r;
    id_nxt   = id_r;
    left_nxt = left_r;
    skip_nxt = skip_r;
    seen_nxt = seen_r;
    for (int i = 0; i < 8; i++) pay_nxt[i] = pay_r[i];
    res      = '0;
    off      = rec_size(id_r) - left_r;
    wr_idx   = 3'(off - 4'(PAYLOAD_FIRST));
    sz       = rec_size(in_data_byte);

    if (in_fire) begin
      if (pos_r < POS_W'(MAX_FRAME_BYTES)) begin
        if (pos_r == POS_W'(HDR_CHANNEL_POS)) begin
          acc_nxt = (in_data_byte[3:0] == in_ch_r) || (in_data_byte[3:0] == wake_ch_r);
        end else if (pos_r >= POS_W'(FIRST_REC_POS) && acc_r && !stop_r) begin
          if (skip_r != 3'd0) begin
            skip_nxt = skip_r - 3'd1;
          end else if (left_r != 4'd0) begin
            if (off >= 4'(PAYLOAD_FIRST) && off < 4'(PAYLOAD_END)) begin
              pay_nxt[wr_idx] = in_data_byte;
            end
            left_nxt = left_r - 4'd1;
            if (left_r == 4'd1) begin
              res.report_valid = 1'b1;
              res.sensor_kind  = kind_of(id_r);
              res.value_x      = {pay_nxt[1], pay_nxt[0]};
              res.value_y      = {pay_nxt[3], pay_nxt[2]};
              res.value_z      = {pay_nxt[5], pay_nxt[4]};
              // real part only on quaternion kinds
              if (res.sensor_kind >= KIND_ROTATION) begin
                res.value_w = {pay_nxt[7], pay_nxt[6]};
              end
              seen_nxt = 1'b1;
            end
          end else if (pos_r == POS_W'(FIRST_REC_POS) && in_data_byte == ID_BASE_TS) begin
            skip_nxt = TS_SKIP_BYTES;
          end else if (sz == 4'd0) begin
            stop_nxt = 1'b1;
          end else if (in_data_byte == ID_REBASE) begin
            skip_nxt = TS_SKIP_BYTES;
          end else begin
            id_nxt   = in_data_byte;
            left_nxt = sz - 4'd1;
          end
        end
        pos_nxt = pos_r + POS_W'(1);
      end

      // final byte: report frame status and clear for the next frame
      if (in_last_byte) begin
        res.frame_done    = acc_nxt && (pos_r >= POS_W'(FIRST_REC_POS));
        res.frame_updated = res.frame_done && seen_nxt;
        pos_nxt  = '0;
        acc_nxt  = 1'b0;
        stop_nxt = 1'b0;
        id_nxt   = '0;
        left_nxt = '0;
        skip_nxt = '0;
        seen_nxt = 1'b0;
      end
    end
  end

  assign emit = in_fire && (res.report_valid || res.frame_done);

  // Output register / skid control
  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (out_take) skid_v_nxt = 1'b0;
    end else if (emit) begin
      if (out_v_r && !out_take) skid_v_nxt = 1'b1;
      else                      out_v_nxt  = 1'b1;
    end else if (out_take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ch_r   <= 4'd3;
      wake_ch_r <= 4'd4;
      pos_r     <= '0;
      acc_r     <= 1'b0;
      stop_r    <= 1'b0;
      id_r      <= '0;
      left_r    <= '0;
      skip_r    <= '0;
      seen_r    <= 1'b0;
      out_v_r   <= 1'b0;
      skid_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_INPUT_CH: in_ch_r   <= cfg_wdata;
          CFG_IDX_WAKE_CH:  wake_ch_r <= cfg_wdata;
          default: ;
        endcase
      end
      pos_r    <= pos_nxt;
      acc_r    <= acc_nxt;
      stop_r   <= stop_nxt;
      id_r     <= id_nxt;
      left_r   <= left_nxt;
      skip_r   <= skip_nxt;
      seen_r   <= seen_nxt;
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  // Payload and result data: no reset needed
  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) pay_r[i] <= pay_nxt[i];
    if (skid_v_r) begin
      if (out_take) out_d_r <= skid_d_r;
    end else if (emit) begin
      if (out_v_r && !out_take) skid_d_r <= res;
      else                      out_d_r  <= res;
    end
  end

  assign out_valid         = out_v_r;
  assign out_report_valid  = out_d_r.report_valid;
  assign out_sensor_kind   = out_d_r.sensor_kind;
  assign out_value_x       = out_d_r.value_x;
  assign out_value_y       = out_d_r.value_y;
  assign out_value_z       = out_d_r.value_z;
  assign out_value_w       = out_d_r.value_w;
  assign out_frame_done    = out_d_r.frame_done;
  assign out_frame_updated = out_d_r.frame_updated;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // skid only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register full with output register empty");

  // frame_updated only ever rides with frame_done
  a_updated_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (!out_d_r.frame_updated || out_d_r.frame_done))
    else $error("frame_updated without frame_done");

  // a final byte always leaves the position at the frame start
  a_last_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last_byte) |=> (pos_r == '0 && !acc_r && !seen_r))
    else $error("frame state not cleared after final byte");

  // never skipping and collecting a record at once
  a_skip_excl_record: assert property (@(posedge clk) disable iff (!rst_n)
    !(skip_r != 3'd0 && left_r != 4'd0))
    else $error("timestamp skip overlaps a report record");

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for the sensor-hub frame parser: byte stream in, report beats checked.
`timescale 1ns / 1ps

module testbench;
  import shtp_pkg::*;

  localparam int unsigned FRAME_LIMIT  = 512;   // byte index from which the block ignores data
  localparam int unsigned PHASE_BYTES  = 90;    // random bytes per configuration phase
  localparam int unsigned HOLD_CYCLES  = 80;    // long receiver hold-off, enough to back up input
  localparam int unsigned QUIET_LIMIT  = 1000;  // cycles without any handshake before giving up
  localparam int unsigned DRAIN_CYCLES = 4;     // slack after the last expected beat is taken

  // How a directed row is checked: by the predictor, as "no beat", or against a typed beat
  typedef enum logic [1:0] {EXP_PREDICT, EXP_NOTHING, EXP_TYPED} exp_mode_e;

  typedef struct packed {
    logic [7:0]   data;
    logic         last;
    exp_mode_e    mode;
    shtp_result_t res;
  } dir_row_t;

  localparam shtp_result_t RES_NONE = '0;
  // accel report with x at the negative extreme, y at the positive one, z = -1; frame ends too
  localparam shtp_result_t RES_ACCEL_EXTREMES =
    {1'b1, KIND_ACCEL, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 1'b1, 1'b1};
  // frame accepted but nothing decoded
  localparam shtp_result_t RES_DONE_EMPTY = {68'd0, 1'b1, 1'b0};

  localparam logic [7:0] REPORT_IDS [9] = '{ID_ACCEL, ID_GYRO, ID_MAG, ID_LINEAR, ID_GRAVITY,
                                            ID_ROTATION, ID_GAME_ROT, ID_GEO_ROT, ID_REBASE};

  // Directed opening: extremes, short frame, rejected channel, unknown id on the wake channel
  dir_row_t dir_tab [25] = '{
    // accel record on input channel 3, high nibble of the channel byte set
    '{8'h00, 1'b0, EXP_PREDICT, RES_NONE},
    '{8'h00, 1'b0, EXP_PREDICT, RES_NONE},
    '{8'hF3, 1'b0, EXP_PREDICT, RES_NONE},
    '{8'h00, 1'b0, EXP_PREDICT, RES_NONE},
    '{ID_ACCEL, 1'b0, EXP_PREDICT, RES_NONE},
    '{8'hFF, 1'b0, EXP_PREDICT, RES_NONE},
    '{8'h00, 1'b0, EXP_PREDICT, RES_NONE},
    '{8'hAA, 1'b0, EXP_PREDICT, RES_NONE},
    '{8'h00, 1'b0, EXP_PREDICT, RES_NONE},
    '{8'h80, 1'b0, EXP_PREDICT, RES_NONE},
    '{8'hFF, 1'b0, EXP_PREDICT, RES_NONE},
    '{8'h7F, 1'b0, EXP_PREDICT, RES_NONE},
    '{8'hFF, 1'b0, EXP_PREDICT, RES_NONE},
    '{8'hFF, 1'b1, EXP_TYPED,   RES_ACCEL_EXTREMES},
    // one-byte frame: ends before the header is complete
    '{8'hFF, 1'b1, EXP_NOTHING, RES_NONE},
    // channel 5 is neither input nor wake
    '{8'h00, 1'b0, EXP_PREDICT, RES_NONE},
    '{8'h00, 1'b0, EXP_PREDICT, RES_NONE},
    '{8'h05, 1'b0, EXP_PREDICT, RES_NONE},
    '{8'h00, 1'b0, EXP_PREDICT, RES_NONE},
    '{ID_ACCEL, 1'b1, EXP_NOTHING, RES_NONE},
    // wake channel 4, id 0x07 is unknown: frame done, nothing updated
    '{8'h00, 1'b0, EXP_PREDICT, RES_NONE},
    '{8'h00, 1'b0, EXP_PREDICT, RES_NONE},
    '{8'h04, 1'b0, EXP_PREDICT, RES_NONE},
    '{8'h00, 1'b0, EXP_PREDICT, RES_NONE},
    '{8'h07, 1'b1, EXP_TYPED,   RES_DONE_EMPTY}
  };

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_index;
  logic [3:0]         cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_data_byte;
  logic               in_last_byte;
  logic               out_valid;
  logic               out_stall;
  logic               out_report_valid;
  logic [2:0]         out_sensor_kind;
  logic signed [15:0] out_value_x;
  logic signed [15:0] out_value_y;
  logic signed [15:0] out_value_z;
  logic signed [15:0] out_value_w;
  logic               out_frame_done;
  logic               out_frame_updated;

  shtp_sensor_report_parser #(
    .MAX_FRAME_BYTES(FRAME_LIMIT)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_report_valid (out_report_valid),
    .out_sensor_kind  (out_sensor_kind),
    .out_value_x      (out_value_x),
    .out_value_y      (out_value_y),
    .out_value_z      (out_value_z),
    .out_value_w      (out_value_w),
    .out_frame_done   (out_frame_done),
    .out_frame_updated(out_frame_updated)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Parser mirror: frame position, channel verdict, record progress, payload
  // ---------------------------------------------------------------------------
  logic [3:0]   in_ch;
  logic [3:0]   wake_ch;
  int unsigned  frame_pos;
  bit           chan_ok;
  bit           parse_halted;
  logic [7:0]   cur_id;
  logic [3:0]   rec_left;
  logic [2:0]   skip_left;
  logic [7:0]   pay [8];
  bit           seen_report;

  shtp_result_t beats_due [$];   // expected result beats, oldest first
  logic [7:0]   frame_bytes [$]; // frame under construction
  int           mismatches = 0;

  int unsigned  tx_idle_pct;
  int unsigned  rx_stall_pct;
  bit           hold_req = 1'b0;

  // Length of a record including its id byte; zero marks an unknown id
  function automatic int unsigned rec_len(input logic [7:0] id);
    case (id)
      ID_REBASE: return 5;
      ID_ACCEL, ID_GYRO, ID_MAG, ID_LINEAR, ID_GRAVITY: return 10;
      ID_GAME_ROT: return 12;
      ID_ROTATION, ID_GEO_ROT: return 14;
      default: return 0;
    endcase
  endfunction

  function automatic logic [2:0] kind_for_id(input logic [7:0] id);
    case (id)
      ID_ACCEL:    return KIND_ACCEL;
      ID_GYRO:     return KIND_GYRO;
      ID_MAG:      return KIND_MAG;
      ID_LINEAR:   return KIND_LINEAR;
      ID_GRAVITY:  return KIND_GRAVITY;
      ID_ROTATION: return KIND_ROTATION;
      ID_GAME_ROT: return KIND_GAME_ROT;
      default:     return KIND_GEO_ROT;
    endcase
  endfunction

  task automatic clear_frame_state();
    frame_pos    = 0;
    chan_ok      = 1'b0;
    parse_halted = 1'b0;
    cur_id       = '0;
    rec_left     = '0;
    skip_left    = '0;
    seen_report  = 1'b0;
  endtask

  // One byte through the mirror; has_res says whether it yields a result beat
  task automatic parse_byte(input logic [7:0] b, input logic last,
                            output bit has_res, output shtp_result_t res);
    int unsigned at;
    int unsigned offs;
    int unsigned len;
    bit          reported;
    bit          done;
    at       = frame_pos;
    reported = 1'b0;
    done     = 1'b0;
    res      = '0;
    if (at < FRAME_LIMIT) begin
      if (at == HDR_CHANNEL_POS) begin
        chan_ok = (b[3:0] == in_ch) || (b[3:0] == wake_ch);
      end else if (at >= FIRST_REC_POS && chan_ok && !parse_halted) begin
        if (skip_left != 0) begin
          skip_left--;
        end else if (rec_left != 0) begin
          offs = rec_len(cur_id) - rec_left;
          if (offs >= PAYLOAD_FIRST && offs < PAYLOAD_END)
            pay[3'(offs - PAYLOAD_FIRST)] = b;
          rec_left--;
          if (rec_left == 0) begin
            reported          = 1'b1;
            res.report_valid  = 1'b1;
            res.sensor_kind   = kind_for_id(cur_id);
            res.value_x       = {pay[1], pay[0]};
            res.value_y       = {pay[3], pay[2]};
            res.value_z       = {pay[5], pay[4]};
            // only quaternion kinds carry a real part
            if (res.sensor_kind >= KIND_ROTATION)
              res.value_w = {pay[7], pay[6]};
            seen_report = 1'b1;
          end
        end else if (at == FIRST_REC_POS && b == ID_BASE_TS) begin
          skip_left = TS_SKIP_BYTES;
        end else begin
          len = rec_len(b);
          if (len == 0) begin
            parse_halted = 1'b1;   // unknown id, or a base timestamp past offset 4
          end else if (b == ID_REBASE) begin
            skip_left = TS_SKIP_BYTES;
          end else begin
            cur_id   = b;
            rec_left = 4'(len - 1);
          end
        end
      end
      frame_pos = at + 1;   // sticks at the limit for overlong frames
    end
    if (last) begin
      done              = chan_ok && at >= FIRST_REC_POS;
      res.frame_done    = done;
      res.frame_updated = done && seen_report;
      clear_frame_state();
    end
    has_res = reported || done;
  endtask

  // ---------------------------------------------------------------------------
  // Input side: one byte per call, random idle cycles before the beat
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic last,
                           input exp_mode_e mode, input shtp_result_t typed_res);
    bit           got;
    shtp_result_t res;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    parse_byte(b, last, got, res);
    case (mode)
      EXP_PREDICT: begin
        if (got)
          beats_due.push_back(res);
      end
      EXP_TYPED: beats_due.push_back(typed_res);
      default: ;
    endcase
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i])
      push_byte(frame_bytes[i], i == frame_bytes.size() - 1, EXP_PREDICT, RES_NONE);
  endtask

  // Drop valid, then wait for every expected beat plus a little slack
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (beats_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [3:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_IDX_INPUT_CH)
      in_ch = val;
    else
      wake_ch = val;
  endtask

  // ---------------------------------------------------------------------------
  // Frame generation
  // ---------------------------------------------------------------------------
  // Payload bytes lean towards the 16-bit extremes
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [3:0] pick_channel();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45)
      return in_ch;
    else if (roll < 80)
      return wake_ch;
    return 4'($urandom_range(15));
  endfunction

  task automatic add_header(input logic [3:0] ch);
    frame_bytes.push_back(8'($urandom_range(255)));
    frame_bytes.push_back(8'($urandom_range(255)));
    frame_bytes.push_back({4'($urandom_range(15)), ch});
    frame_bytes.push_back(8'($urandom_range(255)));
  endtask

  // Appends one record; with allow_bad, now and then one that halts the parse unless at offset 4
  task automatic add_record(input bit allow_bad);
    logic [7:0]  id;
    int unsigned roll;
    roll = $urandom_range(99);
    if (allow_bad && roll < 9) begin
      if (roll < 6) begin
        do id = 8'($urandom_range(255)); while (rec_len(id) != 0);
      end else begin
        id = ID_BASE_TS;   // only legal at offset 4
      end
      frame_bytes.push_back(id);
      repeat ($urandom_range(6)) frame_bytes.push_back(payload_byte());
    end else begin
      id = REPORT_IDS[$urandom_range(8)];
      frame_bytes.push_back(id);
      repeat (rec_len(id) - 1) frame_bytes.push_back(payload_byte());
    end
  endtask

  task automatic build_frame();
    int unsigned roll;
    int unsigned cut;
    frame_bytes.delete();
    roll = $urandom_range(99);
    if (roll < 15) begin
      // noise: short or headerless junk
      repeat ($urandom_range(12, 1)) frame_bytes.push_back(8'($urandom_range(255)));
    end else begin
      add_header(pick_channel());
      if ($urandom_range(1))
        repeat (5) frame_bytes.push_back(frame_bytes.size() == 4 ? ID_BASE_TS : payload_byte());
      repeat ($urandom_range(3, 1)) add_record(1'b1);
      // truncated last record
      if ($urandom_range(9) == 0) begin
        cut = $urandom_range(5, 1);
        while (cut != 0 && frame_bytes.size() > 1) begin
          void'(frame_bytes.pop_back());
          cut--;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Each accepted result beat against the oldest expectation
  always @(posedge clk) begin : result_check
    shtp_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (beats_due.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        want = beats_due.pop_front();
        check_field("report_valid",  want.report_valid,  out_report_valid);
        check_field("sensor_kind",   want.sensor_kind,   out_sensor_kind);
        check_field("value_x",       want.value_x,       out_value_x);
        check_field("value_y",       want.value_y,       out_value_y);
        check_field("value_z",       want.value_z,       out_value_z);
        check_field("value_w",       want.value_w,       out_value_w);
        check_field("frame_done",    want.frame_done,    out_frame_done);
        check_field("frame_updated", want.frame_updated, out_frame_updated);
      end
    end
  end

  // Watchdog: cycles in which neither side completes a beat
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed table, four random phases with fresh channels
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_IDX_INPUT_CH;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    tx_idle_pct  = 16;
    rx_stall_pct = 48;
    in_ch        = 4'd3;
    wake_ch      = 4'd4;
    foreach (pay[i])
      pay[i] = '0;
    clear_frame_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset channel values are used as they stand here
    foreach (dir_tab[i])
      push_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].mode, dir_tab[i].res);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          write_cfg(CFG_IDX_INPUT_CH, 4'd0);
          write_cfg(CFG_IDX_WAKE_CH, 4'd15);
        end
        1: begin
          write_cfg(CFG_IDX_INPUT_CH, 4'd15);
          write_cfg(CFG_IDX_WAKE_CH, 4'd0);
          tx_idle_pct  = 48;
          rx_stall_pct = 16;
        end
        2: begin
          // both channels the same
          write_cfg(CFG_IDX_INPUT_CH, 4'($urandom_range(15)));
          write_cfg(CFG_IDX_WAKE_CH, in_ch);
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        default: begin
          write_cfg(CFG_IDX_INPUT_CH, 4'($urandom_range(15)));
          write_cfg(CFG_IDX_WAKE_CH, 4'($urandom_range(15)));
        end
      endcase
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_frame();
        send_frame();
        sent += frame_bytes.size();
        // receiver holds off while bytes keep coming, so the block backs up
        if (ph == 2 && sent >= 20 && sent - frame_bytes.size() < 20)
          hold_req = 1'b1;
      end
    end

    settle();
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
